### hdl/quaternion_rotate_vector_macros.svh
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_macros.svh
// assertion macros shared by the rotation pipeline
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_MACROS_SVH

// same-cycle implication, checked while out of reset
`define QRV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define QRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg
// widths and latencies of the quaternion rotation pipeline
// ----------------------------------------------------------------------------
package qrv_pkg;

  localparam int DW     = 16;           // field width
  localparam int TW     = 34;           // q*(0,v) terms
  localparam int PW     = TW + DW;      // t times a quaternion part
  localparam int NW     = 52;           // rotated numerators
  localparam int N2W    = 33;           // squared norm
  localparam int RW     = NW + 1;       // divider remainder
  localparam int QB     = 16;           // quotient bits per divide

  localparam int DIV_LAT = QB + 3;      // sign, setup, bit stages, saturate
  localparam int PRE_LAT = 4;           // products, sums, products, sums
  localparam int LAT     = PRE_LAT + DIV_LAT + 1;

  localparam logic [DW-1:0] SAT_POS = 16'h7FFF;
  localparam logic [DW-1:0] SAT_NEG = 16'h8000;

endpackage

### hdl/qrv_intf.sv
// ----------------------------------------------------------------------------
// qrv_intf
// input and result channels of the quaternion rotation block
// ----------------------------------------------------------------------------
interface qrv_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] q_w;
  logic signed [15:0] q_x;
  logic signed [15:0] q_y;
  logic signed [15:0] q_z;
  logic signed [15:0] v_x;
  logic signed [15:0] v_y;
  logic signed [15:0] v_z;

  modport source (output valid, q_w, q_x, q_y, q_z, v_x, v_y, v_z, input ready);
  modport sink   (input valid, q_w, q_x, q_y, q_z, v_x, v_y, v_z, output ready);
endinterface

interface qrv_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r_x;
  logic signed [15:0] r_y;
  logic signed [15:0] r_z;
  logic               zero_quat;
  logic               saturated;

  modport source (output valid, r_x, r_y, r_z, zero_quat, saturated, input ready);
  modport sink   (input valid, r_x, r_y, r_z, zero_quat, saturated, output ready);
endinterface

### hdl/qrv_div.sv
// ----------------------------------------------------------------------------
// qrv_div
// pipelined signed divide, round half away from zero, 16-bit saturate
// ----------------------------------------------------------------------------
module qrv_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qrv_pkg::NW-1:0] num,
  input  logic [qrv_pkg::N2W-1:0]       den,
  output logic [qrv_pkg::DW-1:0]        res,
  output logic                          clip
);
  import qrv_pkg::*;

  // sign split
  logic            a_neg_r;
  logic [NW-1:0]   a_mag_r;
  logic [N2W-1:0]  a_den_r;

  // bit stages, index 0 is the setup stage
  logic [RW-1:0]   rem_r [QB+1];
  logic [N2W:0]    d2_r  [QB+1];
  logic [QB-1:0]   qt_r  [QB+1];
  logic            neg_r [QB+1];
  logic            ovf_r [QB+1];

  logic [RW-1:0]   m_nxt;
  logic [RW-1:0]   lim_nxt;
  logic [RW-1:0]   rem_nxt [QB];
  logic [QB-1:0]   qt_nxt  [QB];
  logic [RW-1:0]   sub     [QB];

  logic [DW-1:0]   res_nxt;
  logic            clip_nxt;
  logic [DW-1:0]   res_r;
  logic            clip_r;

  always_comb begin
    m_nxt   = {a_mag_r, 1'b0} + RW'(a_den_r);
    lim_nxt = RW'({a_den_r, 1'b0}) << QB;
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      sub[k]     = RW'(d2_r[k]) << (QB - 1 - k);
      rem_nxt[k] = rem_r[k];
      qt_nxt[k]  = qt_r[k];
      if (rem_r[k] >= sub[k]) begin
        rem_nxt[k]            = rem_r[k] - sub[k];
        qt_nxt[k][QB - 1 - k] = 1'b1;
      end
    end
  end

  // saturate the finished quotient
  always_comb begin
    res_nxt  = qt_r[QB];
    clip_nxt = 1'b0;
    if (ovf_r[QB]) begin
      clip_nxt = 1'b1;
      res_nxt  = neg_r[QB] ? SAT_NEG : SAT_POS;
    end else if (neg_r[QB]) begin
      if (qt_r[QB] > SAT_NEG) begin
        clip_nxt = 1'b1;
        res_nxt  = SAT_NEG;
      end else begin
        res_nxt  = DW'(~qt_r[QB] + 1'b1);
      end
    end else if (qt_r[QB][QB-1]) begin
      clip_nxt = 1'b1;
      res_nxt  = SAT_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg_r  <= num[NW-1];
      a_mag_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      a_den_r  <= den;

      rem_r[0] <= m_nxt;
      d2_r[0]  <= {a_den_r, 1'b0};
      qt_r[0]  <= '0;
      neg_r[0] <= a_neg_r;
      ovf_r[0] <= m_nxt >= lim_nxt;

      for (int k = 0; k < QB; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        d2_r[k+1]  <= d2_r[k];
        qt_r[k+1]  <= qt_nxt[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end

      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign res  = res_r;
  assign clip = clip_r;

endmodule

### hdl/quaternion_rotate_vector.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// rotates a Q7.8 vector by a Q2.13 quaternion of any length
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | beat contents
//  in_ch    | in  | valid / ready   | q_w q_x q_y q_z v_x v_y v_z
//  out_ch   | out | valid / ready   | r_x r_y r_z zero_quat saturated
//
// one beat in per cycle, one beat out per cycle while the output is not stalled
// new beats enter while earlier ones are in flight; each norm divide has 16 one-bit restoring stages
// rst_n clears all valid bits, the data registers are not reset
// a stalled output freezes every stage together, nothing is dropped
// ----------------------------------------------------------------------------
`include "quaternion_rotate_vector_macros.svh"

module quaternion_rotate_vector (
  input logic      clk,
  input logic      rst_n,
  qrv_in_if.sink   in_ch,
  qrv_out_if.source out_ch
);
  import qrv_pkg::*;

  // whole pipeline advances when the output register is free
  logic en;
  logic [LAT-1:0] v_r;

  assign en          = !v_r[LAT-1] || out_ch.ready;
  // no beat is taken while in reset
  assign in_ch.ready = rst_n && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_ch.valid};
    end
  end

  // stage 1: v products for t = q*(0,v), and norm squares
  logic signed [2*DW-1:0] xvx_r, yvy_r, zvz_r, wvx_r, yvz_r, zvy_r;
  logic signed [2*DW-1:0] wvy_r, xvz_r, zvx_r, wvz_r, xvy_r, yvx_r;
  logic signed [2*DW-1:0] ww_r, xx_r, yy_r, zz_r;
  logic signed [DW-1:0]   w1_r, x1_r, y1_r, z1_r;

  // stage 2: t terms and squared norm
  logic signed [TW-1:0]   tw_r, tx_r, ty_r, tz_r;
  logic [N2W-1:0]         n2_r, n2b_r, n2c_r;
  logic signed [DW-1:0]   w2_r, x2_r, y2_r, z2_r;

  // stage 3: t times quaternion parts
  logic signed [PW-1:0]   a1_r, a2_r, a3_r, a4_r;
  logic signed [PW-1:0]   b1_r, b2_r, b3_r, b4_r;
  logic signed [PW-1:0]   c1_r, c2_r, c3_r, c4_r;

  // stage 4: numerators
  logic signed [NW-1:0]   nx_r, ny_r, nz_r;
  logic                   zq_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      xvx_r <= in_ch.q_x * in_ch.v_x;
      yvy_r <= in_ch.q_y * in_ch.v_y;
      zvz_r <= in_ch.q_z * in_ch.v_z;
      wvx_r <= in_ch.q_w * in_ch.v_x;
      yvz_r <= in_ch.q_y * in_ch.v_z;
      zvy_r <= in_ch.q_z * in_ch.v_y;
      wvy_r <= in_ch.q_w * in_ch.v_y;
      xvz_r <= in_ch.q_x * in_ch.v_z;
      zvx_r <= in_ch.q_z * in_ch.v_x;
      wvz_r <= in_ch.q_w * in_ch.v_z;
      xvy_r <= in_ch.q_x * in_ch.v_y;
      yvx_r <= in_ch.q_y * in_ch.v_x;
      ww_r  <= in_ch.q_w * in_ch.q_w;
      xx_r  <= in_ch.q_x * in_ch.q_x;
      yy_r  <= in_ch.q_y * in_ch.q_y;
      zz_r  <= in_ch.q_z * in_ch.q_z;
      w1_r  <= in_ch.q_w;
      x1_r  <= in_ch.q_x;
      y1_r  <= in_ch.q_y;
      z1_r  <= in_ch.q_z;

      tw_r <= -TW'(xvx_r) - TW'(yvy_r) - TW'(zvz_r);
      tx_r <=  TW'(wvx_r) + TW'(yvz_r) - TW'(zvy_r);
      ty_r <=  TW'(wvy_r) - TW'(xvz_r) + TW'(zvx_r);
      tz_r <=  TW'(wvz_r) + TW'(xvy_r) - TW'(yvx_r);
      // squares are never negative, so the sign bit is dropped
      n2_r <= N2W'(unsigned'(ww_r)) + N2W'(unsigned'(xx_r))
            + N2W'(unsigned'(yy_r)) + N2W'(unsigned'(zz_r));
      w2_r <= w1_r;
      x2_r <= x1_r;
      y2_r <= y1_r;
      z2_r <= z1_r;

      // vector part of t * conj(q)
      a1_r <= tw_r * x2_r;
      a2_r <= tx_r * w2_r;
      a3_r <= ty_r * z2_r;
      a4_r <= tz_r * y2_r;
      b1_r <= tw_r * y2_r;
      b2_r <= tx_r * z2_r;
      b3_r <= ty_r * w2_r;
      b4_r <= tz_r * x2_r;
      c1_r <= tw_r * z2_r;
      c2_r <= tx_r * y2_r;
      c3_r <= ty_r * x2_r;
      c4_r <= tz_r * w2_r;
      n2b_r <= n2_r;

      nx_r  <= -NW'(a1_r) + NW'(a2_r) - NW'(a3_r) + NW'(a4_r);
      ny_r  <= -NW'(b1_r) + NW'(b2_r) + NW'(b3_r) - NW'(b4_r);
      nz_r  <= -NW'(c1_r) - NW'(c2_r) + NW'(c3_r) + NW'(c4_r);
      n2c_r <= n2b_r;

      // zero flag rides alongside the divide
      zq_r[0] <= (n2c_r == '0);
      for (int k = 1; k < DIV_LAT; k++) begin
        zq_r[k] <= zq_r[k-1];
      end
    end
  end

  logic [DW-1:0] qx, qy, qz;
  logic          cx, cy, cz;

  qrv_div u_div_x (.clk(clk), .en(en), .num(nx_r), .den(n2c_r), .res(qx), .clip(cx));
  qrv_div u_div_y (.clk(clk), .en(en), .num(ny_r), .den(n2c_r), .res(qy), .clip(cy));
  qrv_div u_div_z (.clk(clk), .en(en), .num(nz_r), .den(n2c_r), .res(qz), .clip(cz));

  // output register: zero quaternion forces a zero vector
  logic signed [DW-1:0] rx_r, ry_r, rz_r;
  logic                 zero_r, sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= zq_r[DIV_LAT-1];
      rx_r   <= zq_r[DIV_LAT-1] ? '0 : qx;
      ry_r   <= zq_r[DIV_LAT-1] ? '0 : qy;
      rz_r   <= zq_r[DIV_LAT-1] ? '0 : qz;
      sat_r  <= !zq_r[DIV_LAT-1] && (cx || cy || cz);
    end
  end

  assign out_ch.valid     = v_r[LAT-1];
  assign out_ch.r_x       = rx_r;
  assign out_ch.r_y       = ry_r;
  assign out_ch.r_z       = rz_r;
  assign out_ch.zero_quat = zero_r;
  assign out_ch.saturated = sat_r;

  // checks
  logic            zero_vec;
  logic            rail_hit;
  logic [3*DW+1:0] out_beat;

  assign zero_vec = rx_r == '0 && ry_r == '0 && rz_r == '0 && !sat_r;
  assign rail_hit = rx_r == SAT_POS || rx_r == SAT_NEG || ry_r == SAT_POS
                 || ry_r == SAT_NEG || rz_r == SAT_POS || rz_r == SAT_NEG;
  assign out_beat = {rx_r, ry_r, rz_r, zero_r, sat_r};

  `QRV_ASSERT_NOW(a_zero_out, out_ch.valid && out_ch.zero_quat, zero_vec, "zero beat has data")
  `QRV_ASSERT_NOW(a_sat_rail, out_ch.valid && out_ch.saturated, rail_hit, "no clipped part")
  `QRV_ASSERT_NEXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_beat), "stall lost beat")

endmodule
